// ----- design/iso8583_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8583_pkg
// Shared constants, codes and types of the ISO 8583 message parser.
// ----------------------------------------------------------------------------
package iso8583_pkg;

  // Table and length sizing
  localparam int FIELD_COUNT = 129;
  localparam int FIELD_BITS  = $clog2(FIELD_COUNT);
  localparam int LENGTH_BITS = 10;
  localparam int ACC_BITS    = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // Bitmap layout
  localparam int BITMAP_BYTES   = 16;
  localparam int BITMAP_IDX     = $clog2(BITMAP_BYTES);
  localparam int PRIMARY_LAST   = 64;
  localparam int SECONDARY_LAST = 128;
  localparam int PRIMARY_BYTES  = 8;
  localparam int BITMAP_FIELD   = 1;

  // ASCII digit bounds
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  // Parse phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_TYPE   = 3'd1;
  localparam logic [2:0] PH_BITMAP = 3'd2;
  localparam logic [2:0] PH_PREFIX = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_SETUP  = 3'd5;

  // Byte kinds
  localparam logic [1:0] KIND_TYPE   = 2'd0;
  localparam logic [1:0] KIND_BITMAP = 2'd1;
  localparam logic [1:0] KIND_DIGIT  = 2'd2;
  localparam logic [1:0] KIND_DATA   = 2'd3;

  // Field formats
  localparam logic [1:0] FMT_NUMERIC = 2'd0;
  localparam logic [1:0] FMT_ALPHA   = 2'd1;
  localparam logic [1:0] FMT_BINARY  = 2'd2;
  localparam logic [1:0] FMT_UNKNOWN = 2'd3;

  // Item actions
  localparam logic ACT_DEFINE = 1'b0;
  localparam logic ACT_BYTE   = 1'b1;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] max_len;
    logic [1:0]             digits;
    logic [1:0]             format;
  } fdef_t;

  typedef struct packed {
    logic [7:0] field_number;
    logic [7:0] byte_value;
    logic [1:0] byte_kind;
    logic       field_end;
    logic       message_end;
    logic       length_over_max;
    logic       bad_length_digit;
    logic       bad_format;
  } result_t;

endpackage

// ----- design/iso8583_message_parser_unit.sv -----
`timescale 1ns / 1ps
// A message byte's result is registered in the result register, or in the skid entry while the output stalls.
// Throughput: one item per cycle while the input is not stalled; each byte is one pass through the parse logic.
// Definition writes produce no result.
// Input stalls only when both the result register and the skid entry are full.
// Reset clears parse state, valid flags and non-empty flags; the definition memory is not cleared.
// ----------------------------------------------------------------------------
// iso8583_message_parser_unit
// ISO 8583 ASCII message unpacker: takes field definitions and message bytes,
// and tags each byte with its field, kind and error flags.
// ----------------------------------------------------------------------------
module iso8583_message_parser_unit
  import iso8583_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   action,
  input  logic [7:0]             def_index,
  input  logic [LENGTH_BITS-1:0] def_max_len,
  input  logic [1:0]             def_len_digits,
  input  logic [1:0]             def_format,
  input  logic [7:0]             data_byte,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [7:0]             field_number,
  output logic [7:0]             byte_value,
  output logic [1:0]             byte_kind,
  output logic                   field_end,
  output logic                   message_end,
  output logic                   length_over_max,
  output logic                   bad_length_digit,
  output logic                   bad_format
);

  logic                   take;
  logic                   def_we;
  logic                   byte_fire;
  fdef_t                  wr_def;
  fdef_t                  cur_def;
  logic [FIELD_BITS-1:0]  def_addr;
  logic [FIELD_COUNT-1:0] nonempty;
  result_t                res;
  result_t                out_res;

  // Split transfers into definition writes and message bytes
  assign take      = item_valid && item_ready;
  assign def_we    = take && (action == ACT_DEFINE);
  assign byte_fire = take && (action == ACT_BYTE);

  always_comb begin
    wr_def.max_len = (def_max_len > LEN_MAX) ? LEN_MAX : def_max_len;
    wr_def.digits  = def_len_digits;
    wr_def.format  = def_format;
  end

  iso8583_def_table u_table (
    .clk      (clk),
    .rst      (rst),
    .we       (def_we),
    .wr_index (def_index),
    .wr_def   (wr_def),
    .rd_addr  (def_addr),
    .rd_def   (cur_def),
    .nonempty (nonempty)
  );

  iso8583_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .byte_fire (byte_fire),
    .data_byte (data_byte),
    .cur_def   (cur_def),
    .nonempty  (nonempty),
    .def_addr  (def_addr),
    .res       (res)
  );

  iso8583_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (byte_fire),
    .push_res  (res),
    .can_take  (item_ready),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_res   (out_res)
  );

  // Unpack the result
  assign field_number     = out_res.field_number;
  assign byte_value       = out_res.byte_value;
  assign byte_kind        = out_res.byte_kind;
  assign field_end        = out_res.field_end;
  assign message_end      = out_res.message_end;
  assign length_over_max  = out_res.length_over_max;
  assign bad_length_digit = out_res.bad_length_digit;
  assign bad_format       = out_res.bad_format;

endmodule

// ----- design/iso8583_def_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8583_def_table
// Field definition memory with a registered, write-through read port and a
// per-field "non-empty" flag vector used by the presence scan.
// ----------------------------------------------------------------------------
module iso8583_def_table
  import iso8583_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   we,
  input  logic [7:0]             wr_index,
  input  fdef_t                  wr_def,
  input  logic [FIELD_BITS-1:0]  rd_addr,
  output fdef_t                  rd_def,
  output logic [FIELD_COUNT-1:0] nonempty
);

  fdef_t mem [0:FIELD_COUNT-1];
  logic  wr_ok;

  assign wr_ok = we && (wr_index < 8'(FIELD_COUNT));

  // Write the entry; read returns the new value on an address match
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_index[FIELD_BITS-1:0]] <= wr_def;
    end
    if (wr_ok && (wr_index[FIELD_BITS-1:0] == rd_addr)) begin
      rd_def <= wr_def;
    end else begin
      rd_def <= mem[rd_addr];
    end
  end

  // Track which fields carry any bytes at all
  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else if (wr_ok) begin
      nonempty[wr_index[FIELD_BITS-1:0]] <= (wr_def.digits != 2'd0) ||
                                            (wr_def.max_len != '0);
    end
  end

endmodule

// ----- design/iso8583_field_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8583_field_scan
// Priority encoder that finds the next present, non-empty field above a
// starting field number, within the primary or extended bitmap range.
// ----------------------------------------------------------------------------
module iso8583_field_scan
  import iso8583_pkg::*;
(
  input  logic [SECONDARY_LAST-1:0] present,
  input  logic [FIELD_COUNT-1:0]    nonempty,
  input  logic [7:0]                after_field,
  input  logic                      extended,
  output logic                      found,
  output logic [7:0]                next_field
);

  logic [8:0] last_field;

  assign last_field = extended ? 9'(SECONDARY_LAST) : 9'(PRIMARY_LAST);

  // Walk down so the lowest candidate wins
  always_comb begin
    found      = 1'b0;
    next_field = '0;
    for (int f = SECONDARY_LAST; f >= 2; f--) begin
      if ((f < FIELD_COUNT) && present[f-1] && nonempty[f] &&
          (9'(f) > {1'b0, after_field}) && (9'(f) <= last_field)) begin
        found      = 1'b1;
        next_field = 8'(f);
      end
    end
  end

endmodule

// ----- design/iso8583_parse_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8583_parse_core
// Message byte tagger: type code, bitmap, length prefix and field body
// phases, with the decimal length accumulate and the next-field step.
// ----------------------------------------------------------------------------
module iso8583_parse_core
  import iso8583_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_fire,
  input  logic [7:0]             data_byte,
  input  fdef_t                  cur_def,
  input  logic [FIELD_COUNT-1:0] nonempty,
  output logic [FIELD_BITS-1:0]  def_addr,
  output result_t                res
);

  logic [2:0]             phase, phase_next, ph_e;
  logic [7:0]             cur, cur_next, cur_e;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next, bleft_e;
  logic [LENGTH_BITS-1:0] acc, acc_next, acc_e;
  logic [1:0]             digits_left, digits_left_next, pleft_e;
  logic                   ext, ext_next, ext_e;
  logic                   sat, sat_next;
  logic                   fover, fover_next;

  logic [7:0]                bitmap [0:BITMAP_BYTES-1];
  logic [7:0]                bitmap_e [0:BITMAP_BYTES-1];
  logic                      bm_we;
  logic [BITMAP_IDX-1:0]     bm_k;
  logic [SECONDARY_LAST-1:0] present;
  logic [7:0]                scan_from;
  logic                      scan_found;
  logic [7:0]                scan_next;

  // Resolve the effective phase: finish field setup, open a new message
  always_comb begin
    ph_e    = phase;
    cur_e   = cur;
    bleft_e = bytes_left;
    pleft_e = digits_left;
    acc_e   = acc;
    if (phase == PH_SETUP) begin
      if (cur_def.digits != 2'd0) begin
        ph_e    = PH_PREFIX;
        pleft_e = cur_def.digits;
      end else begin
        ph_e    = PH_BODY;
        bleft_e = cur_def.max_len;
      end
    end
    if (byte_fire && (phase == PH_IDLE)) begin
      cur_e = '0;
      if (cur_def.max_len != '0) begin
        ph_e    = PH_TYPE;
        bleft_e = cur_def.max_len;
      end else begin
        ph_e  = PH_BITMAP;
        acc_e = '0;
      end
    end
  end

  // Merge the incoming bitmap byte for the scan
  assign bm_we     = byte_fire && (ph_e == PH_BITMAP);
  assign bm_k      = acc_e[BITMAP_IDX-1:0];
  assign ext_e     = (bm_we && (bm_k == '0)) ? data_byte[7] : ext;
  assign scan_from = (ph_e == PH_BITMAP) ? 8'(BITMAP_FIELD) : cur_e;

  for (genvar k = 0; k < BITMAP_BYTES; k++) begin : g_bm
    assign bitmap_e[k] = (bm_we && (bm_k == BITMAP_IDX'(k))) ? data_byte : bitmap[k];
    for (genvar j = 0; j < 8; j++) begin : g_bit
      assign present[k*8 + 7 - j] = bitmap_e[k][j];
    end
  end

  iso8583_field_scan u_scan (
    .present     (present),
    .nonempty    (nonempty),
    .after_field (scan_from),
    .extended    (ext_e),
    .found       (scan_found),
    .next_field  (scan_next)
  );

  // Tag the byte and step the parse state
  always_comb begin
    logic                   adv;
    logic [4:0]             k1;
    logic [4:0]             total;
    logic [3:0]             dv;
    logic [ACC_BITS-1:0]    acc_w;
    logic [LENGTH_BITS-1:0] acc_n;
    logic [LENGTH_BITS-1:0] body;
    logic                   sat_n;

    adv   = 1'b0;
    k1    = {1'b0, bm_k} + 5'd1;
    total = ext_e ? 5'(BITMAP_BYTES) : 5'(PRIMARY_BYTES);
    dv    = '0;
    acc_w = '0;
    acc_n = '0;
    body  = '0;
    sat_n = sat;

    phase_next       = ph_e;
    cur_next         = cur_e;
    bytes_left_next  = bleft_e;
    digits_left_next = pleft_e;
    acc_next         = acc_e;
    ext_next         = ext_e;
    sat_next         = sat;
    fover_next       = fover;

    res            = '0;
    res.byte_value = data_byte;

    if (byte_fire) begin
      case (ph_e)
        PH_TYPE: begin
          res.field_number = '0;
          res.byte_kind    = KIND_TYPE;
          if (bleft_e != '0) begin
            bytes_left_next = bleft_e - 1'b1;
          end
          if (bytes_left_next == '0) begin
            res.field_end = 1'b1;
            phase_next    = PH_BITMAP;
            acc_next      = '0;
          end
        end
        PH_BITMAP: begin
          res.field_number = 8'(BITMAP_FIELD);
          res.byte_kind    = KIND_BITMAP;
          acc_next         = LENGTH_BITS'(k1);
          if (k1 >= total) begin
            res.field_end = 1'b1;
            acc_next      = '0;
            adv           = 1'b1;
          end
        end
        PH_PREFIX: begin
          res.field_number = cur_e;
          res.bad_format   = (cur_def.format == FMT_UNKNOWN);
          res.byte_kind    = ((cur_def.format == FMT_NUMERIC) ||
                              (cur_def.format == FMT_ALPHA)) ? KIND_DIGIT : KIND_DATA;
          if ((data_byte >= ASCII_ZERO) && (data_byte <= ASCII_NINE)) begin
            dv = 4'(data_byte - ASCII_ZERO);
          end else begin
            res.bad_length_digit = 1'b1;
          end
          acc_w = ACC_BITS'(acc_e) * ACC_BITS'(10) + ACC_BITS'(dv);
          if (acc_w > ACC_BITS'(LEN_MAX)) begin
            acc_n = LEN_MAX;
            sat_n = 1'b1;
          end else begin
            acc_n = acc_w[LENGTH_BITS-1:0];
          end
          acc_next = acc_n;
          sat_next = sat_n;
          if (pleft_e != 2'd0) begin
            digits_left_next = pleft_e - 2'd1;
          end
          if (digits_left_next == 2'd0) begin
            fover_next          = sat_n || (acc_n > cur_def.max_len);
            res.length_over_max = fover_next;
            body                = acc_n;
            if (cur_def.format == FMT_UNKNOWN) begin
              body = (acc_n > LENGTH_BITS'(cur_def.digits)) ?
                     acc_n - LENGTH_BITS'(cur_def.digits) : '0;
            end
            if (body == '0) begin
              res.field_end = 1'b1;
              adv           = 1'b1;
            end else begin
              phase_next      = PH_BODY;
              bytes_left_next = body;
            end
          end
        end
        PH_BODY: begin
          res.field_number    = cur_e;
          res.byte_kind       = KIND_DATA;
          res.bad_format      = (cur_def.format == FMT_UNKNOWN);
          res.length_over_max = fover;
          if (bleft_e != '0) begin
            bytes_left_next = bleft_e - 1'b1;
          end
          if (bytes_left_next == '0) begin
            res.field_end = 1'b1;
            adv           = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // Advance to the next present field, or close the message
    if (adv) begin
      if (scan_found) begin
        cur_next   = scan_next;
        phase_next = PH_SETUP;
        acc_next   = '0;
        sat_next   = 1'b0;
        fover_next = 1'b0;
      end else begin
        res.message_end  = 1'b1;
        phase_next       = PH_IDLE;
        cur_next         = '0;
        bytes_left_next  = '0;
        acc_next         = '0;
        digits_left_next = '0;
        ext_next         = 1'b0;
        sat_next         = 1'b0;
        fover_next       = 1'b0;
      end
    end
  end

  // Read the definition of the field that is current after this edge
  assign def_addr = cur_next[FIELD_BITS-1:0];

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cur         <= '0;
      bytes_left  <= '0;
      acc         <= '0;
      digits_left <= '0;
      ext         <= 1'b0;
      sat         <= 1'b0;
      fover       <= 1'b0;
    end else begin
      phase       <= phase_next;
      cur         <= cur_next;
      bytes_left  <= bytes_left_next;
      acc         <= acc_next;
      digits_left <= digits_left_next;
      ext         <= ext_next;
      sat         <= sat_next;
      fover       <= fover_next;
    end
  end

  // Store bitmap bytes
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap[bm_k] <= data_byte;
    end
  end

endmodule

// ----- design/iso8583_out_skid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8583_out_skid
// Result register plus one skid entry, so a new item can be taken while a
// finished result is still waiting downstream.
// ----------------------------------------------------------------------------
module iso8583_out_skid
  import iso8583_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    can_take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    main_valid, skid_valid;
  result_t main_res, skid_res;
  logic    pop;

  assign pop       = main_valid && out_ready;
  assign can_take  = !skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  // Hold valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (main_valid && !out_ready) begin
          skid_valid <= 1'b1;
        end else begin
          main_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          main_valid <= 1'b0;
        end
      end
    end
  end

  // Move payloads
  always_ff @(posedge clk) begin
    if (push) begin
      if (main_valid && !out_ready) begin
        skid_res <= push_res;
      end else begin
        main_res <= push_res;
      end
    end else if (pop && skid_valid) begin
      main_res <= skid_res;
    end
  end

endmodule

// ----- dv/iso8583_message_parser_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8583_message_parser_unit_test
// Self-checking bench for the ISO 8583 message parser. Loads the whole field
// definition table, runs two hand-built messages over the special cases,
// then streams random well-formed messages with some noise. Each byte is
// predicted on transfer and every result is compared against the oldest
// prediction, while both handshakes idle at random.
// ----------------------------------------------------------------------------
module iso8583_message_parser_unit_test;
  import iso8583_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 350;
  localparam int TAIL_CYCLES  = 20;

  // Message-level predictor and store of expected tagged bytes
  class parse_scoreboard;
    logic [LENGTH_BITS-1:0] def_len    [FIELD_COUNT];
    logic [1:0]             def_digits [FIELD_COUNT];
    logic [1:0]             def_fmt    [FIELD_COUNT];
    logic [127:0]           present;
    logic [2:0]             phase;
    int unsigned            cur_field, left, acc, digits_left;
    bit                     ext, acc_sat, over_mark;
    result_t                tagged_q[$];
    int                     errors, bytes_in, defs_in, messages_done;
    int                     over_seen, bad_digit_seen, bad_fmt_seen;

    function new();
      clear_message();
    endfunction

    function void clear_message();
      present     = '0;
      phase       = PH_IDLE;
      cur_field   = 0;
      left        = 0;
      acc         = 0;
      digits_left = 0;
      ext         = 1'b0;
      acc_sat     = 1'b0;
      over_mark   = 1'b0;
    endfunction

    function int unsigned next_present(int unsigned from);
      int unsigned last;
      last = ext ? SECONDARY_LAST : PRIMARY_LAST;
      for (int unsigned i = from; i <= last; i++) begin
        if (i < FIELD_COUNT && present[127 - ((i - 1) & 127)] &&
            (def_digits[i] != 0 || def_len[i] != 0))
          return i;
      end
      return 0;
    endfunction

    // Move to the next present field; return 1 when the message is over
    function bit advance(int unsigned f);
      int unsigned n;
      n = next_present(f + 1);
      if (n == 0) begin
        clear_message();
        messages_done++;
        return 1'b1;
      end
      cur_field = n;
      acc       = 0;
      acc_sat   = 1'b0;
      over_mark = 1'b0;
      if (def_digits[n] != 0) begin
        phase       = PH_PREFIX;
        digits_left = def_digits[n];
      end else begin
        phase = PH_BODY;
        left  = def_len[n];
      end
      return 1'b0;
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function string fmt_res(result_t r);
      return $sformatf("fn=%0d v=%h k=%0d fe=%b me=%b ov=%b bd=%b bf=%b",
                       r.field_number, r.byte_value, r.byte_kind, r.field_end,
                       r.message_end, r.length_over_max, r.bad_length_digit,
                       r.bad_format);
    endfunction

    // Update the table or predict the tag of one accepted message byte
    function void note_input(logic act, logic [7:0] idx, logic [LENGTH_BITS-1:0] ml,
                             logic [1:0] dg, logic [1:0] fm, logic [7:0] b);
      result_t     r;
      int unsigned k, total, dv, nacc, body, f;
      r = '0;
      r.byte_value = b;
      if (act == ACT_DEFINE) begin
        if (idx < FIELD_COUNT) begin
          def_len[idx]    = ml;
          def_digits[idx] = dg;
          def_fmt[idx]    = fm;
          defs_in++;
        end
        return;
      end
      bytes_in++;
      if (phase == PH_IDLE) begin
        cur_field = 0;
        if (def_len[0] != 0) begin
          phase = PH_TYPE;
          left  = def_len[0];
        end else begin
          phase = PH_BITMAP;
          acc   = 0;
        end
      end
      case (phase)
        PH_TYPE: begin
          r.field_number = 8'd0;
          r.byte_kind    = KIND_TYPE;
          if (left != 0) left--;
          if (left == 0) begin
            r.field_end = 1'b1;
            phase       = PH_BITMAP;
            acc         = 0;
          end
        end
        PH_BITMAP: begin
          k = acc & 15;
          r.field_number = 8'(BITMAP_FIELD);
          r.byte_kind    = KIND_BITMAP;
          if (k == 0) ext = b[7];
          total = ext ? BITMAP_BYTES : PRIMARY_BYTES;
          present[127 - 8 * k -: 8] = present[127 - 8 * k -: 8] | b;
          k++;
          acc = k;
          if (k >= total) begin
            r.field_end   = 1'b1;
            acc           = 0;
            r.message_end = advance(BITMAP_FIELD);
          end
        end
        PH_PREFIX: begin
          f = cur_field;
          r.field_number = 8'(f);
          r.bad_format   = (def_fmt[f] == FMT_UNKNOWN);
          r.byte_kind    = (def_fmt[f] == FMT_NUMERIC || def_fmt[f] == FMT_ALPHA) ?
                           KIND_DIGIT : KIND_DATA;
          if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
            dv = b - ASCII_ZERO;
          end else begin
            dv = 0;
            r.bad_length_digit = 1'b1;
          end
          nacc = acc * 10 + dv;
          if (nacc > LEN_MAX) begin
            nacc    = LEN_MAX;
            acc_sat = 1'b1;
          end
          acc = nacc;
          if (digits_left != 0) digits_left--;
          if (digits_left == 0) begin
            over_mark         = acc_sat || (acc > def_len[f]);
            r.length_over_max = over_mark;
            body = acc;
            if (def_fmt[f] == FMT_UNKNOWN)
              body = (acc > def_digits[f]) ? acc - def_digits[f] : 0;
            if (body == 0) begin
              r.field_end   = 1'b1;
              r.message_end = advance(f);
            end else begin
              phase = PH_BODY;
              left  = body;
            end
          end
        end
        default: begin
          f = cur_field;
          r.field_number    = 8'(f);
          r.byte_kind       = KIND_DATA;
          r.bad_format      = (def_fmt[f] == FMT_UNKNOWN);
          r.length_over_max = over_mark;
          if (left != 0) left--;
          if (left == 0) begin
            r.field_end   = 1'b1;
            r.message_end = advance(f);
          end
        end
      endcase
      if (r.length_over_max) over_seen++;
      if (r.bad_length_digit) bad_digit_seen++;
      if (r.bad_format) bad_fmt_seen++;
      tagged_q.push_back(r);
    endfunction

    // Compare one result transfer with the oldest prediction
    task check_result(result_t got);
      result_t exp;
      if (tagged_q.size() == 0) begin
        report($sformatf("unexpected result %s", fmt_res(got)));
        return;
      end
      exp = tagged_q.pop_front();
      if (got.field_number !== exp.field_number || got.byte_value !== exp.byte_value ||
          got.byte_kind !== exp.byte_kind || got.field_end !== exp.field_end ||
          got.message_end !== exp.message_end ||
          got.length_over_max !== exp.length_over_max ||
          got.bad_length_digit !== exp.bad_length_digit ||
          got.bad_format !== exp.bad_format)
        report($sformatf("got %s, exp %s", fmt_res(got), fmt_res(exp)));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  logic                   action;
  logic [7:0]             def_index;
  logic [LENGTH_BITS-1:0] def_max_len;
  logic [1:0]             def_len_digits;
  logic [1:0]             def_format;
  logic [7:0]             data_byte;
  logic                   result_valid;
  logic                   result_ready;
  logic [7:0]             field_number;
  logic [7:0]             byte_value;
  logic [1:0]             byte_kind;
  logic                   field_end;
  logic                   message_end;
  logic                   length_over_max;
  logic                   bad_length_digit;
  logic                   bad_format;

  parse_scoreboard sb;
  logic [127:0]    bitmap_plan;
  int              forced_len_q[$];
  int              prefix_target;
  int              item_count;
  int              cycle_count;
  bit              burst;
  bit              noisy;
  bit              draining;

  iso8583_message_parser_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .action           (action),
    .def_index        (def_index),
    .def_max_len      (def_max_len),
    .def_len_digits   (def_len_digits),
    .def_format       (def_format),
    .data_byte        (data_byte),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .field_number     (field_number),
    .byte_value       (byte_value),
    .byte_kind        (byte_kind),
    .field_end        (field_end),
    .message_end      (message_end),
    .length_over_max  (length_over_max),
    .bad_length_digit (bad_length_digit),
    .bad_format       (bad_format)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Present one item, hold it until its transfer, then record it
  task automatic drive_item(input logic act, input logic [7:0] idx,
                            input logic [LENGTH_BITS-1:0] ml, input logic [1:0] dg,
                            input logic [1:0] fm, input logic [7:0] b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid     <= 1'b1;
    action         <= act;
    def_index      <= idx;
    def_max_len    <= ml;
    def_len_digits <= dg;
    def_format     <= fm;
    data_byte      <= b;
    @(posedge clk);
    while (item_ready !== 1'b1) @(posedge clk);
    sb.note_input(act, idx, ml, dg, fm, b);
    if (!(act == ACT_DEFINE && idx >= FIELD_COUNT)) item_count++;
  endtask

  task automatic write_def(input int idx, input int ml, input int dg, input int fm);
    drive_item(ACT_DEFINE, 8'(idx), LENGTH_BITS'(ml), 2'(dg), 2'(fm),
               8'($urandom_range(0, 255)));
  endtask

  // Draw a definition: fixed fields stay short, variable ones span the range
  task automatic random_def(input int idx);
    int dg, fm, ml;
    dg = $urandom_range(0, 3);
    fm = $urandom_range(0, 3);
    if (dg == 0)
      ml = ($urandom_range(0, 3) == 0) ? 0 :
           ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    else
      ml = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 15);
    if (idx == 0) ml = $urandom_range(0, 4);
    write_def(idx, ml, dg, fm);
  endtask

  // Pick the next message byte from where the parse stands
  task automatic choose_byte(output logic [7:0] b);
    logic [2:0]  ph;
    int unsigned k, f, dg, ml, cap, p10;
    ph = sb.phase;
    k  = sb.acc & 15;
    if (ph == PH_IDLE) begin
      ph = (sb.def_len[0] != 0) ? PH_TYPE : PH_BITMAP;
      k  = 0;
    end
    b = 8'($urandom_range(0, 255));
    if (ph == PH_BITMAP) begin
      b = bitmap_plan[127 - 8 * k -: 8];
    end else if (ph == PH_PREFIX) begin
      f  = sb.cur_field;
      dg = sb.def_digits[f];
      ml = sb.def_len[f];
      // Choose the parsed length on the first prefix byte of a field
      if (sb.digits_left == dg) begin
        cap = 1;
        repeat (dg) cap *= 10;
        cap -= 1;
        if (forced_len_q.size() != 0)
          prefix_target = forced_len_q.pop_front();
        else if ($urandom_range(0, 29) == 0)
          prefix_target = -1;
        else if (sb.def_fmt[f] == FMT_UNKNOWN)
          prefix_target = ($urandom_range(0, 4) == 0) ? $urandom_range(0, dg - 1) :
                          dg + $urandom_range(0, 6);
        else if (ml <= 16 && $urandom_range(0, 7) == 0)
          prefix_target = ml + $urandom_range(1, 4);
        else
          prefix_target = $urandom_range(0, (ml < 12) ? ml : 12);
        if (prefix_target > int'(cap)) prefix_target = cap;
      end
      if (prefix_target < 0 || sb.digits_left == 0) begin
        b = 8'($urandom_range(0, 245));
        if (b >= ASCII_ZERO) b = b + 8'd10;
      end else begin
        p10 = 1;
        repeat (sb.digits_left - 1) p10 *= 10;
        b = 8'(ASCII_ZERO + (prefix_target / p10) % 10);
      end
    end
    if (noisy && $urandom_range(0, 24) == 0) b = 8'($urandom_range(0, 255));
  endtask

  // Send bytes until the parser closes the message
  task automatic send_message();
    logic [7:0] b;
    int         idx;
    do begin
      if (noisy && $urandom_range(0, 39) == 0) begin
        idx = ($urandom_range(0, 1) == 0) ? sb.cur_field :
              ($urandom_range(0, 7) == 0) ? $urandom_range(FIELD_COUNT, 255) :
              $urandom_range(0, FIELD_COUNT - 1);
        random_def(idx);
      end
      choose_byte(b);
      drive_item(ACT_BYTE, 8'($urandom_range(0, 255)),
                 LENGTH_BITS'($urandom_range(0, 1023)),
                 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), b);
    end while (sb.phase != PH_IDLE);
  endtask

  function automatic logic [127:0] field_bit(int f);
    return 128'b1 << (128 - f);
  endfunction

  // Accept results with random stalls and check each one
  initial begin
    result_t got;
    int      gap;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = (burst || draining) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
      got.field_number     = field_number;
      got.byte_value       = byte_value;
      got.byte_kind        = byte_kind;
      got.field_end        = field_end;
      got.message_end      = message_end;
      got.length_over_max  = length_over_max;
      got.bad_length_digit = bad_length_digit;
      got.bad_format       = bad_format;
      sb.check_result(got);
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int start_count, n;
    sb             = new();
    burst          = 1'b0;
    noisy          = 1'b0;
    draining       = 1'b0;
    item_count     = 0;
    prefix_target  = 0;
    rst            <= 1'b1;
    item_valid     <= 1'b0;
    action         <= ACT_DEFINE;
    def_index      <= '0;
    def_max_len    <= '0;
    def_len_digits <= '0;
    def_format     <= '0;
    data_byte      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Load every table entry so no parse reads an unwritten one
    for (int i = 0; i < FIELD_COUNT; i++) random_def(i);

    // Primary bitmap over the per-field special cases, no type code
    write_def(0, 0, 3, FMT_UNKNOWN);
    write_def(2, 2, 0, FMT_NUMERIC);
    write_def(3, 5, 1, FMT_NUMERIC);
    write_def(4, 3, 2, FMT_ALPHA);
    write_def(5, 999, 2, FMT_BINARY);
    write_def(6, 4, 1, FMT_UNKNOWN);
    write_def(7, 9, 2, FMT_UNKNOWN);
    write_def(8, 0, 0, FMT_ALPHA);
    write_def(64, 1, 0, FMT_BINARY);
    write_def(200, 7, 1, FMT_ALPHA);
    bitmap_plan = '0;
    for (int f = 2; f <= 8; f++) bitmap_plan |= field_bit(f);
    bitmap_plan |= field_bit(PRIMARY_LAST);
    // Non-digit prefix, over maximum, kept binary prefix, unknown, short unknown
    forced_len_q = '{-1, 5, 2, 3, 1};
    send_message();

    // Secondary bitmap with a three-digit length and the last field
    write_def(0, 4, 0, FMT_NUMERIC);
    write_def(100, 999, 3, FMT_NUMERIC);
    write_def(SECONDARY_LAST, 2, 0, FMT_ALPHA);
    bitmap_plan = field_bit(1) | field_bit(100) | field_bit(SECONDARY_LAST);
    forced_len_q = '{105};
    send_message();

    // Random messages with noise, redefinitions and idle stretches
    noisy       = 1'b1;
    start_count = item_count;
    while (item_count < start_count + RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 2) == 0);
      n = $urandom_range(0, 3);
      repeat (n) random_def(($urandom_range(0, 7) == 0) ? $urandom_range(FIELD_COUNT, 255) :
                            $urandom_range(0, FIELD_COUNT - 1));
      bitmap_plan = '0;
      if ($urandom_range(0, 2) == 0) bitmap_plan |= field_bit(1);
      for (int f = 2; f <= SECONDARY_LAST; f++)
        if ($urandom_range(0, (f <= PRIMARY_LAST) ? 15 : 31) == 0)
          bitmap_plan |= field_bit(f);
      send_message();
    end

    // Drain and settle
    item_valid <= 1'b0;
    burst      = 1'b0;
    draining   = 1'b1;
    while (sb.tagged_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d message bytes in %0d messages and %0d definition writes",
             sb.bytes_in, sb.messages_done, sb.defs_in);
    $display("Flagged bytes: %0d over maximum, %0d bad digit, %0d bad format",
             sb.over_seen, sb.bad_digit_seen, sb.bad_fmt_seen);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
